// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define SPT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Antecedent implies consequent at the following edge.
`define SPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPT_ASSERT(lbl, clk, rstn, prop, msg)
`define SPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared sizes, codes, state encoding and structs of the sorted priority table.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W = 2;
    localparam int ID_W   = 31;
    localparam int PRI_W  = 8;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int WORD_W = ID_W + PRI_W;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_SCAN,
        ST_INS_PLACE,
        ST_RM_SCAN,
        ST_RM_END,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
        logic [OCC_W-1:0]  removed_count;
        logic [ID_W-1:0]   read_id;
        logic [PRI_W-1:0]  read_priority;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/spt_ram.sv
// ----------------------------------------------------------------------------
// spt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/spt_ctrl.sv
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer that walks the table one slot a cycle through the shared compare.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [spt_pkg::MODE_W-1:0]  mode,
    input  logic [spt_pkg::ID_W-1:0]    entry_id,
    input  logic [spt_pkg::PRI_W-1:0]   priority_req,
    input  logic [spt_pkg::POS_W-1:0]   position,
    output spt_pkg::mem_req_t           mem_req,
    input  logic [spt_pkg::WORD_W-1:0]  rdata,
    output logic                        res_valid,
    input  logic                        res_ready,
    output spt_pkg::result_t            res
);

    import spt_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   hole_reg, hole_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [PRI_W-1:0]   pri_reg, pri_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [ID_W-1:0]    rid_reg, rid_next;
    logic [PRI_W-1:0]   rpri_reg, rpri_next;

    logic [PRI_W-1:0]   d_pri;
    logic [ID_W-1:0]    d_id;
    logic               pri_eq;
    logic               pri_gt;
    logic               ins_move;
    logic               rm_more;
    logic               is_full;
    logic               pos_hit;
    logic [CNT_W-1:0]   hole_m1;
    logic [CNT_W-1:0]   hole_m2;
    logic [CNT_W-1:0]   hole_p1;
    logic [CNT_W-1:0]   idx_p1;
    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   count_p1;
    logic [CNT_W-1:0]   removed_p1;

    assign d_pri = rdata[PRI_W-1:0];
    assign d_id  = rdata[WORD_W-1:PRI_W];

    // shared compare of the slot just read against the requested priority
    assign pri_eq = (d_pri == pri_reg);
    assign pri_gt = (d_pri > pri_reg);

    assign hole_m1    = hole_reg - CNT_W'(1);
    assign hole_m2    = hole_reg - CNT_W'(2);
    assign hole_p1    = hole_reg + CNT_W'(1);
    assign idx_p1     = idx_reg + CNT_W'(1);
    assign count_m1   = count_reg - CNT_W'(1);
    assign count_p1   = count_reg + CNT_W'(1);
    assign removed_p1 = removed_reg + CNT_W'(1);

    // the front slot keeps its place against an equal priority
    assign ins_move = pri_gt || (pri_eq && (hole_reg != CNT_W'(1)));
    assign rm_more  = (idx_p1 < count_reg);
    assign is_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign pos_hit  = (32'(pos_reg) < 32'(count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            hole_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hole_reg  <= hole_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        mode_reg    <= mode_next;
        id_reg      <= id_next;
        pri_reg     <= pri_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        rid_reg     <= rid_next;
        rpri_reg    <= rpri_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    if (is_full)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_INS_PLACE;
                    end
                    else
                    begin
                        state_next = ST_INS_SCAN;
                    end
                end
                else if (mode_reg == MODE_REMOVE)
                begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_RM_SCAN;
                end
                else if (mode_reg == MODE_READ)
                begin
                    state_next = pos_hit ? ST_RD_WAIT : ST_DONE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_INS_SCAN:
            begin
                if (!ins_move || (hole_reg == CNT_W'(1)))
                begin
                    state_next = ST_INS_PLACE;
                end
            end
            ST_INS_PLACE:
            begin
                state_next = ST_DONE;
            end
            ST_RM_SCAN:
            begin
                if (!rm_more)
                begin
                    state_next = ST_RM_END;
                end
            end
            ST_RM_END:
            begin
                state_next = ST_DONE;
            end
            ST_RD_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and memory port
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = hole_reg[IDX_W-1:0];
        mem_req.wdata = rdata;
        mem_req.raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DISPATCH:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    mem_req.raddr = count_m1[IDX_W-1:0];
                end
                else if (mode_reg == MODE_READ)
                begin
                    mem_req.raddr = IDX_W'(pos_reg);
                end
            end
            ST_INS_SCAN:
            begin
                // shift the slot up one and fetch the next one down
                mem_req.we    = ins_move;
                mem_req.raddr = hole_m2[IDX_W-1:0];
            end
            ST_INS_PLACE:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = {id_reg, pri_reg};
            end
            ST_RM_SCAN:
            begin
                // compact kept slots down to the write pointer
                mem_req.we    = !pri_eq;
                mem_req.raddr = idx_p1[IDX_W-1:0];
            end
            ST_RM_END:
            begin
            end
            ST_RD_WAIT:
            begin
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        count_next   = count_reg;
        hole_next    = hole_reg;
        idx_next     = idx_reg;
        removed_next = removed_reg;
        mode_next    = mode_reg;
        id_next      = id_reg;
        pri_next     = pri_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        rid_next     = rid_reg;
        rpri_next    = rpri_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    id_next   = entry_id;
                    pri_next  = priority_req;
                    pos_next  = position;
                end
            end
            ST_DISPATCH:
            begin
                status_next  = STAT_OK;
                removed_next = '0;
                rid_next     = '0;
                rpri_next    = '0;
                idx_next     = '0;
                hole_next    = (mode_reg == MODE_INSERT) ? count_reg : '0;
                if ((mode_reg == MODE_INSERT) && is_full)
                begin
                    status_next = STAT_FULL;
                end
                else if ((mode_reg == MODE_READ) && !pos_hit)
                begin
                    status_next = STAT_EMPTY;
                end
            end
            ST_INS_SCAN:
            begin
                if (ins_move)
                begin
                    hole_next = hole_m1;
                end
            end
            ST_INS_PLACE:
            begin
                count_next = count_p1;
            end
            ST_RM_SCAN:
            begin
                idx_next = idx_p1;
                if (pri_eq)
                begin
                    removed_next = removed_p1;
                end
                else
                begin
                    hole_next = hole_p1;
                end
            end
            ST_RM_END:
            begin
                count_next = hole_reg;
            end
            ST_RD_WAIT:
            begin
                rid_next  = d_id;
                rpri_next = d_pri;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res.status        = status_reg;
    assign res.occupancy     = OCC_W'(count_reg);
    assign res.removed_count = OCC_W'(removed_reg);
    assign res.read_id       = rid_reg;
    assign res.read_priority = rpri_reg;

endmodule

`default_nettype wire

// File: rtl/spt_out.sv
// ----------------------------------------------------------------------------
// spt_out
// Output register stage that holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_valid,
    output logic                        res_ready,
    input  spt_pkg::result_t            res,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [spt_pkg::STAT_W-1:0]  status,
    output logic [spt_pkg::OCC_W-1:0]   occupancy,
    output logic [spt_pkg::OCC_W-1:0]   removed_count,
    output logic [spt_pkg::ID_W-1:0]    read_id,
    output logic [spt_pkg::PRI_W-1:0]   read_priority
);

    import spt_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid     = valid_reg;
    assign status        = data_reg.status;
    assign occupancy     = data_reg.occupancy;
    assign removed_count = data_reg.removed_count;
    assign read_id       = data_reg.read_id;
    assign read_priority = data_reg.read_priority;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_table.sv
// ----------------------------------------------------------------------------
// sorted_priority_table: bounded table of (id, priority) kept in ascending order
// Walk per request: an insert shifts entries up from the last one until its place is found,
// a remove walks every entry, a read fetches one slot; a full insert, an empty remove, a
// missed read and mode 3 go straight to the result. The walk takes one slot a cycle.
// Requests: one at a time; the next is taken the cycle after the output stage takes the result.
// Reset: asynchronous, clears the entry count and the sequencer; slots unwritten.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [spt_pkg::MODE_W-1:0]  mode,
    input  logic [spt_pkg::ID_W-1:0]    entry_id,
    input  logic [spt_pkg::PRI_W-1:0]   priority_req,
    input  logic [spt_pkg::POS_W-1:0]   position,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [spt_pkg::STAT_W-1:0]  status,
    output logic [spt_pkg::OCC_W-1:0]   occupancy,
    output logic [spt_pkg::OCC_W-1:0]   removed_count,
    output logic [spt_pkg::ID_W-1:0]    read_id,
    output logic [spt_pkg::PRI_W-1:0]   read_priority
);

    import spt_pkg::*;

    mem_req_t          mem_req;
    logic [WORD_W-1:0] rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    spt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    spt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .entry_id     (entry_id),
        .priority_req (priority_req),
        .position     (position),
        .mem_req      (mem_req),
        .rdata        (rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    spt_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .occupancy     (occupancy),
        .removed_count (removed_count),
        .read_id       (read_id),
        .read_priority (read_priority)
    );

    // sequencer never offers a result while it takes a request
    `SPT_ASSERT(a_idle_vs_done, clk, rst_n, !(in_ready && res_valid), "ready while result pending")
    // a taken request keeps the sequencer busy on the next cycle
    `SPT_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready,
                     "ready after request")
    // removal counts and read data only come with an ok status
    `SPT_ASSERT(a_fields_ok, clk, rst_n,
                !out_valid || ((removed_count == '0) && (read_id == '0)) || (status == STAT_OK),
                "payload with error status")

endmodule

`default_nettype wire
